// ----- rtl/core/lvfc_pkg.sv -----
`default_nettype none

package lvfc_pkg;

	// Opacity limits and the default fade length in frames
	localparam int ALPHA_MAX       = 31;
	localparam int FADE_FRAMES_DEF = 90;

	localparam int ALPHA_W = 5;
	localparam int COUNT_W = 7;
	localparam int SLOT_W  = 3;
	localparam int MASK_W  = 8;
	localparam int STATE_W = 2;

	// Fade state codes on the result
	localparam logic [STATE_W-1:0] FADE_IDLE = 2'd0;
	localparam logic [STATE_W-1:0] FADE_IN   = 2'd1;
	localparam logic [STATE_W-1:0] FADE_OUT  = 2'd2;

	typedef struct packed {
		logic [SLOT_W-1:0] time_slot;
		logic              hide_request;
	} lvfc_in_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] layer_alpha;
		logic [STATE_W-1:0] fade_state;
		logic [COUNT_W-1:0] frames_left;
	} lvfc_out_t;

	// Persistent fade state carried from frame to frame
	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic [COUNT_W-1:0] count;
		logic               fade_in;
		logic               fade_out;
		logic [SLOT_W-1:0]  last_slot;
		logic               last_hide;
		logic               first;
	} lvfc_state_t;

	localparam lvfc_state_t STATE_RESET = '{
		alpha:     ALPHA_W'(ALPHA_MAX),
		count:     '0,
		fade_in:   1'b0,
		fade_out:  1'b0,
		last_slot: '0,
		last_hide: 1'b0,
		first:     1'b1
	};

endpackage

`default_nettype wire

// ----- rtl/core/lvfc_step.sv -----
`default_nettype none

// Next-state and result logic for one frame tick
module lvfc_step #(
	parameter int FADE_FRAMES = lvfc_pkg::FADE_FRAMES_DEF
) (
	input  wire  lvfc_pkg::lvfc_state_t                cur,
	input  wire  logic [lvfc_pkg::MASK_W-1:0]          mask,
	input  wire  lvfc_pkg::lvfc_in_t                   item,
	output lvfc_pkg::lvfc_state_t                      nxt,
	output lvfc_pkg::lvfc_out_t                        result
);

	localparam int AlphaMax   = lvfc_pkg::ALPHA_MAX;
	localparam int LoadDepth  = 2 ** lvfc_pkg::ALPHA_W;
	localparam int CountDepth = 2 ** lvfc_pkg::COUNT_W;

	// Constant tables, built at elaboration
	logic [lvfc_pkg::COUNT_W-1:0] load_tbl [LoadDepth];
	logic [lvfc_pkg::ALPHA_W-1:0] in_tbl   [CountDepth];
	logic [lvfc_pkg::ALPHA_W-1:0] out_tbl  [CountDepth];

	for (genvar i = 0; i < LoadDepth; i++) begin : g_load
		localparam int Span = (i > AlphaMax) ? AlphaMax : i;
		assign load_tbl[i] = lvfc_pkg::COUNT_W'((FADE_FRAMES * Span) / AlphaMax);
	end

	for (genvar i = 0; i < CountDepth; i++) begin : g_alpha
		localparam int T = (i > FADE_FRAMES) ? FADE_FRAMES : i;
		assign in_tbl[i]  = lvfc_pkg::ALPHA_W'((AlphaMax * (FADE_FRAMES - T)) / FADE_FRAMES);
		assign out_tbl[i] = lvfc_pkg::ALPHA_W'((AlphaMax * T) / FADE_FRAMES);
	end

	logic                          dir_slot;
	logic [lvfc_pkg::ALPHA_W-1:0]  span_slot;
	logic [lvfc_pkg::ALPHA_W-1:0]  span_hide;
	logic [lvfc_pkg::COUNT_W-1:0]  load_slot;
	logic [lvfc_pkg::COUNT_W-1:0]  load_hide;
	lvfc_pkg::lvfc_state_t         st1;
	lvfc_pkg::lvfc_state_t         st2;
	lvfc_pkg::lvfc_state_t         st3;

	// Fade start loads; alpha only moves in the advance step
	assign dir_slot  = mask[item.time_slot];
	assign span_slot = dir_slot ? cur.alpha : (lvfc_pkg::ALPHA_W'(AlphaMax) - cur.alpha);
	assign span_hide = item.hide_request ? cur.alpha
		: (lvfc_pkg::ALPHA_W'(AlphaMax) - cur.alpha);
	assign load_slot = load_tbl[span_slot];
	assign load_hide = load_tbl[span_hide];

	always_comb begin
		// time-of-day check
		st1 = cur;
		if (mask != '0) begin
			if ((item.time_slot != cur.last_slot) || cur.first) begin
				st1.count = load_slot;
				if (load_slot != '0) begin
					st1.fade_out = dir_slot;
					st1.fade_in  = !dir_slot;
				end
				if (cur.first) begin
					st1.count = lvfc_pkg::COUNT_W'(1);
					st1.first = 1'b0;
				end
			end
			st1.last_slot = item.time_slot;
		end

		// hide request check
		st2 = st1;
		if ((item.hide_request != st1.last_hide) || st1.first) begin
			st2.count = load_hide;
			if (load_hide != '0) begin
				st2.fade_out = item.hide_request;
				st2.fade_in  = !item.hide_request;
			end
			if (st1.first) begin
				st2.count = lvfc_pkg::COUNT_W'(1);
				st2.first = 1'b0;
			end
		end
		st2.last_hide = item.hide_request;

		// fade advance, countdown saturates at zero
		st3 = st2;
		if (st2.fade_in || st2.fade_out) begin
			if (st2.count != '0) begin
				st3.count = st2.count - lvfc_pkg::COUNT_W'(1);
			end
			st3.alpha = st2.fade_in ? in_tbl[st3.count] : out_tbl[st3.count];
			if (st3.count == '0) begin
				st3.fade_in  = 1'b0;
				st3.fade_out = 1'b0;
			end
		end
	end

	assign nxt = st3;

	assign result.layer_alpha = st3.alpha;
	assign result.fade_state  = st3.fade_in ? lvfc_pkg::FADE_IN
		: (st3.fade_out ? lvfc_pkg::FADE_OUT : lvfc_pkg::FADE_IDLE);
	assign result.frames_left = st3.count;

endmodule

`default_nettype wire

// ----- rtl/core/layer_visibility_fade_controller.sv -----
`default_nettype none

// Channel   Direction  Payload      Transfer when
// in        input      lvfc_in_t    in_valid  && !in_stall
// out       output     lvfc_out_t   out_valid && !out_stall
// cfg       input      mask, 8 bit  cfg_we
//
// The result passes the input register, then the result register; one tick per cycle sustained while out_stall is low.
// The frame tick is registered at the input, then the whole update runs in one
// combinational pass into the state and result registers.
// Reset restores full opacity, idle fade, mask zero and the first-frame mark.
// A stalled output holds its result; the input stage still drains into it once taken.
module layer_visibility_fade_controller #(
	parameter int FADE_FRAMES = lvfc_pkg::FADE_FRAMES_DEF
) (
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,
	input  wire  logic                          cfg_we,
	input  wire  logic [lvfc_pkg::MASK_W-1:0]   cfg_wdata,
	input  wire  logic                          in_valid,
	output logic                                in_stall,
	input  wire  lvfc_pkg::lvfc_in_t            in_data,
	output logic                                out_valid,
	input  wire  logic                          out_stall,
	output lvfc_pkg::lvfc_out_t                 out_data
);

	logic                         valid_s1;
	lvfc_pkg::lvfc_in_t           data_s1;
	logic [lvfc_pkg::MASK_W-1:0]  mask_q;
	lvfc_pkg::lvfc_state_t        state_q;
	lvfc_pkg::lvfc_state_t        state_nxt;
	lvfc_pkg::lvfc_out_t          result;
	logic                         out_valid_q;
	lvfc_pkg::lvfc_out_t          out_data_q;
	logic                         advance;

	// Stage 1 moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	lvfc_step #(
		.FADE_FRAMES(FADE_FRAMES)
	) u_step (
		.cur    (state_q),
		.mask   (mask_q),
		.item   (data_s1),
		.nxt    (state_nxt),
		.result (result)
	);

	// Fade state, updated once per transferred tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lvfc_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
